// ===== rtl/tvsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tvsf_pkg
// Shared types and constants of the typed value scan filter.
// ----------------------------------------------------------------------------
package tvsf_pkg;

	localparam int WordW = 32;
	localparam int CapW  = 24;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 32;

	typedef enum logic [2:0] {
		KIND_U8  = 3'd0,
		KIND_U16 = 3'd1,
		KIND_U32 = 3'd2,
		KIND_S8  = 3'd3,
		KIND_S16 = 3'd4,
		KIND_S32 = 3'd5,
		KIND_F32 = 3'd6,
		KIND_RSV = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		MODE_EQ   = 3'd0,
		MODE_NE   = 3'd1,
		MODE_CHG  = 3'd2,
		MODE_UNCH = 3'd3,
		MODE_INC  = 3'd4,
		MODE_DEC  = 3'd5,
		MODE_GT   = 3'd6,
		MODE_LT   = 3'd7
	} mode_t;

	localparam logic [CfgIdxW-1:0] REG_KIND   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_TARGET = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CAP    = 2'd3;

	localparam logic [WordW-1:0] MASK8  = 32'h0000_00FF;
	localparam logic [WordW-1:0] MASK16 = 32'h0000_FFFF;
	localparam logic [WordW-1:0] MASK32 = 32'hFFFF_FFFF;

	// classified request passed from front to back
	typedef struct packed {
		logic             first;
		logic             hit;
		logic [WordW-1:0] address;
		logic [WordW-1:0] prev;
		logic [WordW-1:0] cur;
	} req_t;

	localparam int QDepth = 2;

	function automatic logic [WordW-1:0] kind_mask(input kind_t k);
		case (k)
			KIND_U8, KIND_S8:   kind_mask = MASK8;
			KIND_U16, KIND_S16: kind_mask = MASK16;
			default:            kind_mask = MASK32;
		endcase
	endfunction

	function automatic logic is_nan(input logic [WordW-1:0] x);
		is_nan = (x[30:0] > 31'h7F80_0000);
	endfunction

	function automatic logic [WordW-1:0] order_key(input logic [WordW-1:0] raw,
			input kind_t k);
		logic [WordW-1:0] m;
		logic [WordW-1:0] v;
		m = kind_mask(k);
		v = raw & m;
		case (k)
			KIND_S8, KIND_S16, KIND_S32: order_key = v ^ ((m >> 1) + 32'd1);
			KIND_F32: begin
				if (v[30:0] == 31'd0)
					v = '0;
				order_key = v[31] ? ~v : (v | 32'h8000_0000);
			end
			default: order_key = v;
		endcase
	endfunction

endpackage

// ===== rtl/tvsf_front.sv =====
// ----------------------------------------------------------------------------
// tvsf_front
// Takes candidates, runs the typed compare and registers the classified request.
// ----------------------------------------------------------------------------
module tvsf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      first_of_scan,
	input  logic [tvsf_pkg::WordW-1:0] address,
	input  logic [tvsf_pkg::WordW-1:0] current_word,
	input  logic [tvsf_pkg::WordW-1:0] previous_word,
	input  tvsf_pkg::kind_t            kind,
	input  tvsf_pkg::mode_t            mode,
	input  logic [tvsf_pkg::WordW-1:0] target,
	output logic                      req_valid,
	output tvsf_pkg::req_t            req,
	input  logic                      req_stall
);
	import tvsf_pkg::*;

	logic             uses_target;
	logic [WordW-1:0] rhs, ka, kb, m;
	logic             nan_any, hit;
	logic             valid_s1;
	req_t             req_s1;

	always_comb begin
		uses_target = (mode == MODE_EQ) || (mode == MODE_NE) ||
			(mode == MODE_GT) || (mode == MODE_LT);
		rhs = uses_target ? target : previous_word;
		m = kind_mask(kind);
		nan_any = (kind == KIND_F32) && (is_nan(current_word) || is_nan(rhs));
		ka = order_key(current_word, kind);
		kb = order_key(rhs, kind);
		unique case (mode)
			MODE_EQ, MODE_UNCH: hit = (ka == kb);
			MODE_NE, MODE_CHG:  hit = (ka != kb);
			MODE_INC, MODE_GT:  hit = (ka > kb);
			default:            hit = (ka < kb);
		endcase
		hit = hit && !nan_any;
	end

	assign in_stall  = valid_s1 && req_stall;
	assign req_valid = valid_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1.first   <= first_of_scan;
			req_s1.hit     <= hit;
			req_s1.address <= address;
			req_s1.prev    <= previous_word & m;
			req_s1.cur     <= current_word & m;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(req_s1))
		else $error("front stage changed while stalled");

endmodule

// ===== rtl/tvsf_queue.sv =====
// ----------------------------------------------------------------------------
// tvsf_queue
// Short fifo between the compare front and the counting back end.
// ----------------------------------------------------------------------------
module tvsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  tvsf_pkg::req_t wr_req,
	output logic           rd_valid,
	input  logic           rd_stall,
	output tvsf_pkg::req_t rd_req
);
	import tvsf_pkg::*;

	localparam int PtrW = $clog2(QDepth);

	req_t            mem_q [QDepth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0]   cnt_q;
	logic            push, pop;

	assign wr_stall = (cnt_q == (PtrW+1)'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_req   = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PtrW'(QDepth-1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PtrW'(QDepth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_req;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PtrW+1)'(QDepth))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/tvsf_back.sv =====
// ----------------------------------------------------------------------------
// tvsf_back
// Applies the per-scan match count and cap, drives the result register.
// ----------------------------------------------------------------------------
module tvsf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  tvsf_pkg::req_t             req,
	input  logic [tvsf_pkg::CapW-1:0]  cap,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tvsf_pkg::WordW-1:0] match_address,
	output logic [tvsf_pkg::WordW-1:0] match_previous,
	output logic [tvsf_pkg::WordW-1:0] match_current,
	output logic                       cap_reached
);
	import tvsf_pkg::*;

	logic [CapW-1:0] count_q, base, next_cnt;
	logic            take, emit;
	logic            valid_q;

	assign req_stall = valid_q && out_stall;
	assign take      = req_valid && !req_stall;
	assign base      = req.first ? '0 : count_q;
	assign emit      = req.hit && (base < cap);
	assign next_cnt  = base + 1'b1;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (!req_stall)
				valid_q <= take && emit;
			if (take)
				count_q <= emit ? next_cnt : base;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			match_address  <= req.address;
			match_previous <= req.prev;
			match_current  <= req.cur;
			cap_reached    <= (next_cnt == cap);
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit) |=> (count_q <= cap || $past(req.first)))
		else $error("match count passed the cap");
	a_flag_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit) |=> (cap_reached == (count_q == $past(cap))))
		else $error("cap flag disagrees with count");

endmodule

// ===== rtl/typed_value_scan_filter_unit.sv =====
// ----------------------------------------------------------------------------
// typed_value_scan_filter_unit
// Typed compare filter over memory scan candidates with a per-scan result cap.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall   first_of_scan address current_word previous_word
// out      output     out_valid/out_stall match_address match_previous match_current cap_reached
// cfg      input      cfg_valid/cfg_ready cfg_index cfg_data
//
// one candidate per cycle sustained while out_stall is low; a request goes through the
// compare register, two-entry queue and result register before its result leaves.
// the count update is a single 24-bit add and compare in the back stage.
// reset clears valids, queue pointers and the match count; config registers take
// their defaults. each side stalls on its own through the queue.
module typed_value_scan_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          first_of_scan,
	input  logic [tvsf_pkg::WordW-1:0]    address,
	input  logic [tvsf_pkg::WordW-1:0]    current_word,
	input  logic [tvsf_pkg::WordW-1:0]    previous_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tvsf_pkg::WordW-1:0]    match_address,
	output logic [tvsf_pkg::WordW-1:0]    match_previous,
	output logic [tvsf_pkg::WordW-1:0]    match_current,
	output logic                          cap_reached,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tvsf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tvsf_pkg::CfgDataW-1:0] cfg_data
);
	import tvsf_pkg::*;

	kind_t            kind_q;
	mode_t            mode_q;
	logic [WordW-1:0] target_q;
	logic [CapW-1:0]  cap_q;
	logic             f_valid, f_stall, q_valid, q_stall;
	req_t             f_req, q_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_U32;
			mode_q   <= MODE_EQ;
			target_q <= '0;
			cap_q    <= 24'd1048576;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KIND:   kind_q   <= kind_t'(cfg_data[2:0]);
				REG_MODE:   mode_q   <= mode_t'(cfg_data[2:0]);
				REG_TARGET: target_q <= cfg_data;
				default:    cap_q    <= cfg_data[CapW-1:0];
			endcase
		end
	end

	tvsf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .first_of_scan, .address,
		.current_word, .previous_word,
		.kind(kind_q), .mode(mode_q), .target(target_q),
		.req_valid(f_valid), .req(f_req), .req_stall(f_stall)
	);

	tvsf_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_req(f_req),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_req(q_req)
	);

	tvsf_back u_back (
		.clk, .arst_n,
		.req_valid(q_valid), .req_stall(q_stall), .req(q_req), .cap(cap_q),
		.out_valid, .out_stall, .match_address, .match_previous,
		.match_current, .cap_reached
	);

endmodule
